// ===== src/assert_macros.svh =====
// Assertion macros for the block's RTL, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while rst is high.
`define RLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk, off while rst is high.
`define RLE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== src/rle8_pkg.sv =====
// Shared types and constants of the run-length bitmap decoder.
`default_nettype none

package rle8_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int OUT_OFFSET_BITS = 24;

  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam int MAP_DEPTH = 256;

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_MAP   = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic [7:0] ESC_MARK  = 8'd0;
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOI   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic [1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [1:0] REG_ROW_PITCH = 2'd1;
  localparam logic [1:0] REG_PERMUTE   = 2'd2;

  localparam logic [2:0] OP_EMIT    = 3'd0;
  localparam logic [2:0] OP_ADVANCE = 3'd1;
  localparam logic [2:0] OP_EOI     = 3'd2;
  localparam logic [2:0] OP_MAPWR   = 3'd3;
  localparam logic [2:0] OP_START   = 3'd4;

  typedef struct packed {
    logic [2:0]             kind;
    logic [OFFSET_BITS-1:0] amount;
    logic [7:0]             data;
    logic [7:0]             run;
    logic [7:0]             index;
  } op_t;

  typedef struct packed {
    logic [15:0] row_width;
    logic [15:0] row_pitch;
    logic        permute_enable;
  } cfg_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QCNT_BITS-1:0] level;
  } q_status_t;

endpackage

`default_nettype wire

// ===== src/rle8_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rle8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/rle8_queue.sv =====
// Short operation queue between the parser and the write stage.
`default_nettype none

module rle8_queue import rle8_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire op_t       push_op,
  input  wire logic      pop,
  output      op_t       head,
  output      q_status_t status
);

  op_t                  slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.level = level;
  assign status.full  = (level == QCNT_BITS'(QDEPTH));
  assign status.empty = (level == '0);

endmodule

`default_nettype wire

// ===== src/rle8_front.sv =====
// Stream parser: accepts words and turns them into queue operations.
`default_nettype none

module rle8_front import rle8_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       accept,
  input  wire logic [1:0] command,
  input  wire logic [7:0] rle_byte,
  input  wire logic [7:0] map_index,
  input  wire logic [7:0] map_value,
  output      logic       push,
  output      op_t        push_op
);

  localparam logic [2:0] PH_COUNT  = 3'd0;
  localparam logic [2:0] PH_VALUE  = 3'd1;
  localparam logic [2:0] PH_ESCAPE = 3'd2;
  localparam logic [2:0] PH_DX     = 3'd3;
  localparam logic [2:0] PH_DY     = 3'd4;
  localparam logic [2:0] PH_ABS    = 3'd5;
  localparam logic [2:0] PH_PAD    = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  logic [2:0]  phase;
  logic [2:0]  phase_next;
  logic [7:0]  held_count;
  logic [7:0]  held_count_next;
  logic [7:0]  absolute_left;
  logic [7:0]  absolute_left_next;
  logic        pad_pending;
  logic        pad_pending_next;
  logic [16:0] eol_diff;
  logic [23:0] dy_product;

  assign eol_diff   = {1'b0, cfg.row_pitch} - {1'b0, cfg.row_width};
  assign dy_product = 24'(rle_byte) * 24'(cfg.row_pitch);

  always_comb begin
    phase_next         = phase;
    held_count_next    = held_count;
    absolute_left_next = absolute_left;
    pad_pending_next   = pad_pending;
    push               = 1'b0;
    push_op            = '0;
    if (accept) begin
      case (command)
        CMD_MAP: begin
          push          = 1'b1;
          push_op.kind  = OP_MAPWR;
          push_op.data  = map_value;
          push_op.index = map_index;
        end
        CMD_START: begin
          phase_next         = PH_COUNT;
          held_count_next    = '0;
          absolute_left_next = '0;
          pad_pending_next   = 1'b0;
          push               = 1'b1;
          push_op.kind       = OP_START;
        end
        CMD_BYTE: begin
          case (phase)
            PH_COUNT: begin
              if (rle_byte == ESC_MARK) begin
                phase_next = PH_ESCAPE;
              end else begin
                held_count_next = rle_byte;
                phase_next      = PH_VALUE;
              end
            end
            PH_VALUE: begin
              push           = 1'b1;
              push_op.kind   = OP_EMIT;
              push_op.data   = rle_byte;
              push_op.run    = held_count;
              push_op.amount = OFFSET_BITS'(held_count);
              phase_next     = PH_COUNT;
            end
            PH_ESCAPE: begin
              case (rle_byte)
                ESC_EOL: begin
                  push           = 1'b1;
                  push_op.kind   = OP_ADVANCE;
                  push_op.amount = OFFSET_BITS'($signed(eol_diff));
                  phase_next     = PH_COUNT;
                end
                ESC_EOI: begin
                  push         = 1'b1;
                  push_op.kind = OP_EOI;
                  phase_next   = PH_DONE;
                end
                ESC_DELTA: begin
                  phase_next = PH_DX;
                end
                default: begin
                  absolute_left_next = rle_byte;
                  pad_pending_next   = rle_byte[0];
                  phase_next         = PH_ABS;
                end
              endcase
            end
            PH_DX: begin
              push           = 1'b1;
              push_op.kind   = OP_ADVANCE;
              push_op.amount = OFFSET_BITS'(rle_byte);
              phase_next     = PH_DY;
            end
            PH_DY: begin
              push           = 1'b1;
              push_op.kind   = OP_ADVANCE;
              push_op.amount = OFFSET_BITS'(dy_product);
              phase_next     = PH_COUNT;
            end
            PH_ABS: begin
              push               = 1'b1;
              push_op.kind       = OP_EMIT;
              push_op.data       = rle_byte;
              push_op.run        = 8'd1;
              push_op.amount     = OFFSET_BITS'(1);
              absolute_left_next = absolute_left - 8'd1;
              if (absolute_left_next == 8'd0) begin
                phase_next = pad_pending ? PH_PAD : PH_COUNT;
              end
            end
            PH_PAD: begin
              pad_pending_next = 1'b0;
              phase_next       = PH_COUNT;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_COUNT;
      held_count    <= '0;
      absolute_left <= '0;
      pad_pending   <= 1'b0;
    end else begin
      phase         <= phase_next;
      held_count    <= held_count_next;
      absolute_left <= absolute_left_next;
      pad_pending   <= pad_pending_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/rle8_back.sv =====
// Write stage: tracks the offset, looks up colours and drives result words.
`default_nettype none

module rle8_back import rle8_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cfg_t                       cfg,
  input  wire op_t                        head,
  input  wire q_status_t                  q_status,
  output      logic                       pop,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [OUT_OFFSET_BITS-1:0] write_offset,
  output      logic [7:0]                 pixel,
  output      logic [7:0]                 run_length,
  output      logic                       end_of_image
);

  logic [OFFSET_BITS-1:0] offset;
  logic                   s1_valid;
  logic [OFFSET_BITS-1:0] s1_offset;
  logic [7:0]             s1_data;
  logic [7:0]             s1_run;
  logic                   s1_eoi;
  logic                   s1_map;
  logic                   s1_go;
  logic                   out_free;
  logic                   head_emit;
  logic                   head_eoi;
  logic [7:0]             map_rdata;

  assign out_free  = !out_valid || out_ready;
  assign s1_go     = s1_valid && out_free;
  assign pop       = !q_status.empty && (!s1_valid || s1_go);
  assign head_emit = (head.kind == OP_EMIT);
  assign head_eoi  = (head.kind == OP_EOI);

  rle8_ram #(
    .WIDTH(8),
    .DEPTH(MAP_DEPTH)
  ) u_color_map (
    .clk  (clk),
    .we   (pop && (head.kind == OP_MAPWR)),
    .waddr(head.index),
    .wdata(head.data),
    .re   (pop && head_emit),
    .raddr(head.data),
    .rdata(map_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      offset    <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        case (head.kind)
          OP_EMIT, OP_ADVANCE: offset <= offset + head.amount;
          OP_START:            offset <= '0;
          default: begin
          end
        endcase
        s1_valid <= head_emit || head_eoi;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_offset <= offset;
      s1_data   <= head_eoi ? 8'd0 : head.data;
      s1_run    <= head_eoi ? 8'd0 : head.run;
      s1_eoi    <= head_eoi;
      s1_map    <= head_emit && cfg.permute_enable;
    end
    if (s1_go) begin
      write_offset <= OUT_OFFSET_BITS'(s1_offset);
      pixel        <= s1_map ? map_rdata : s1_data;
      run_length   <= s1_run;
      end_of_image <= s1_eoi;
    end
  end

endmodule

`default_nettype wire

// ===== src/rle8_bitmap_decoder.sv =====
// Top level of the 8-bit run-length bitmap decoder.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    command, rle_byte, map_index, map_value
//   out      source     out_valid / out_ready  write_offset, pixel, run_length, end_of_image
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle is taken while in_ready is high; the parser does a single small update per word.
// A result passes through a queue slot, the colour lookup and the output register.
// Synchronous reset clears parser, queue, offset, config and valid flags, not the colour map.
// A four-entry queue lets the parser run on while the output stalls; in_ready drops when full.
`default_nettype none

`include "assert_macros.svh"

module rle8_bitmap_decoder import rle8_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic [1:0]                 command,
  input  wire logic [7:0]                 rle_byte,
  input  wire logic [7:0]                 map_index,
  input  wire logic [7:0]                 map_value,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [OUT_OFFSET_BITS-1:0] write_offset,
  output      logic [7:0]                 pixel,
  output      logic [7:0]                 run_length,
  output      logic                       end_of_image,
  input  wire logic                       cfg_valid,
  output      logic                       cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [15:0]                cfg_data
);

  cfg_t      cfg;
  logic      push;
  op_t       push_op;
  logic      pop;
  op_t       head;
  q_status_t q_status;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_WIDTH: cfg.row_width      <= cfg_data;
        REG_ROW_PITCH: cfg.row_pitch      <= cfg_data;
        REG_PERMUTE:   cfg.permute_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  rle8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (in_valid && in_ready),
    .command  (command),
    .rle_byte (rle_byte),
    .map_index(map_index),
    .map_value(map_value),
    .push     (push),
    .push_op  (push_op)
  );

  rle8_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .head   (head),
    .status (q_status)
  );

  rle8_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .write_offset(write_offset),
    .pixel       (pixel),
    .run_length  (run_length),
    .end_of_image(end_of_image)
  );

  `RLE_ASSERT(a_queue_bound, q_status.level <= QCNT_BITS'(QDEPTH), "queue level beyond depth")
  `RLE_NEVER(a_no_push_full, push && q_status.full && !pop, "push into a full queue")
  `RLE_NEVER(a_eoi_fields, out_valid && end_of_image && |{run_length, pixel}, "end word with data")
  `RLE_NEVER(a_run_nonzero, out_valid && !end_of_image && run_length == 8'd0, "zero-length run")

endmodule

`default_nettype wire
